// ----- rtl/core/gww_pkg.sv -----
// ----------------------------------------------------------------------------
// gww_pkg
// Shared types, codes and constants of the greedy word wrap core.
// ----------------------------------------------------------------------------
package gww_pkg;

  // Word buffer depth default
  localparam int MAX_WORD_DEF = 32;

  // Byte codes
  localparam logic [7:0] NL_BYTE = 8'd10;
  localparam logic [7:0] SP_BYTE = 8'd32;
  localparam logic [7:0] TAB_BYTE = 8'd9;
  localparam logic [7:0] CR_BYTE = 8'd13;

  // Input operation codes
  localparam logic OP_TEXT  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Configuration registers
  localparam int         CFG_ADDR_W     = 3;
  localparam logic       REG_LINE_WIDTH = 1'b0;
  localparam logic [7:0] LINE_WIDTH_RST = 8'd80;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEP,
    ST_WORD,
    ST_PARA1,
    ST_PARA2,
    ST_FIN
  } gww_state_t;

  // Source of an emitted byte
  typedef enum logic [1:0] {
    SEL_NL,
    SEL_SP,
    SEL_WORD
  } byte_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      emit;
    byte_sel_t sel;
    logic      last;
    logic      step;
  } gww_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic place;
    logic flush;
    logic pending;
    logic need_nl;
    logic need_sp;
    logic para;
    logic emit_ok;
    logic rd_last;
  } gww_status_t;

  // Whitespace: tab through carriage return, and space
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = ((c >= TAB_BYTE) && (c <= CR_BYTE)) || (c == SP_BYTE);
  endfunction

endpackage

// ----- rtl/core/gww_if.sv -----
// ----------------------------------------------------------------------------
// gww_if
// Valid/ready channels of the word wrap core: text in, wrapped bytes out.
// ----------------------------------------------------------------------------
interface gww_text_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] char_byte;

  modport source (output valid, output opcode, output char_byte, input ready);
  modport sink (input valid, input opcode, input char_byte, output ready);
endinterface

interface gww_wrap_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       width_error;
  logic       word_overflow;

  modport source (
    output valid, output out_byte, output last_of_run,
    output width_error, output word_overflow, input ready
  );
  modport sink (
    input valid, input out_byte, input last_of_run,
    input width_error, input word_overflow, output ready
  );
endinterface

// ----- rtl/core/gww_datapath.sv -----
// ----------------------------------------------------------------------------
// gww_datapath
// Word store, line and word counters, sticky flags and the output register.
// ----------------------------------------------------------------------------
module gww_datapath
  import gww_pkg::*;
#(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  line_width,
  input  logic        opcode,
  input  logic [7:0]  char_byte,
  input  gww_cmd_t    cmd,
  output gww_status_t status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        width_error,
  output logic        word_overflow
);

  localparam int WL_W  = $clog2(MAX_WORD + 1);
  localparam int AW    = $clog2(MAX_WORD);
  localparam int SUM_W = $clog2(256 + MAX_WORD + 1);

  logic [7:0]      store [MAX_WORD];
  logic [7:0]      rd_data;
  logic [WL_W-1:0] word_length;
  logic [WL_W-1:0] emit_len;
  logic [AW-1:0]   rd_ptr;
  logic [AW-1:0]   rd_ptr_next;
  logic [7:0]      line_length;
  logic            seen_newline;
  logic            paragraph_ended;
  logic            error_sticky;
  logic            overflow_sticky;

  logic             is_nl;
  logic             ll_nz;
  logic [SUM_W-1:0] need;
  logic [7:0]       base;
  logic [SUM_W-1:0] placed;
  logic             placed_err;
  logic [7:0]       ll_placed;
  logic             room;
  logic             wr_en;

  // Decode the offered item and work out the placement of the pending word
  always_comb begin
    is_nl  = (char_byte == NL_BYTE);
    ll_nz  = (line_length != 8'd0);
    need   = SUM_W'(line_length) + SUM_W'(word_length) + SUM_W'(ll_nz);
    status.place   = (opcode == OP_FLUSH) || is_blank(char_byte);
    status.flush   = (opcode == OP_FLUSH);
    status.pending = (word_length != '0);
    status.need_nl = ll_nz && (need > SUM_W'(line_width));
    status.need_sp = ll_nz && !status.need_nl;
    status.para    = (opcode == OP_TEXT) && is_nl && seen_newline && !paragraph_ended;
    status.emit_ok = !out_valid || out_ready;
    status.rd_last = ((WL_W'(rd_ptr) + WL_W'(1)) == emit_len);
    base       = status.need_nl ? 8'd0 : line_length;
    placed     = SUM_W'(base) + SUM_W'(status.need_sp) + SUM_W'(word_length);
    placed_err = status.pending && (placed > SUM_W'(line_width));
    ll_placed  = status.pending ? placed[7:0] : line_length;
    room       = (word_length < WL_W'(MAX_WORD));
    wr_en      = cmd.accept && !status.place && room;
  end

  // Update word, line and paragraph state when an item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length     <= '0;
      emit_len        <= '0;
      line_length     <= 8'd0;
      seen_newline    <= 1'b0;
      paragraph_ended <= 1'b0;
      error_sticky    <= 1'b0;
      overflow_sticky <= 1'b0;
    end else if (cmd.accept) begin
      if (status.place) begin
        error_sticky <= error_sticky | placed_err;
        word_length  <= '0;
        emit_len     <= word_length;
        if (status.flush) begin
          line_length     <= 8'd0;
          seen_newline    <= 1'b0;
          paragraph_ended <= 1'b0;
        end else begin
          line_length <= ll_placed;
          if (is_nl) begin
            if (!seen_newline) begin
              seen_newline <= 1'b1;
            end else if (!paragraph_ended) begin
              line_length     <= 8'd0;
              seen_newline    <= 1'b0;
              paragraph_ended <= 1'b1;
            end
          end
        end
      end else begin
        if (room) begin
          word_length <= word_length + WL_W'(1);
        end else begin
          overflow_sticky <= 1'b1;
        end
        seen_newline    <= 1'b0;
        paragraph_ended <= 1'b0;
      end
    end
  end

  // Advance the read pointer one word byte per emitted beat
  always_comb begin
    if (cmd.accept) begin
      rd_ptr_next = '0;
    end else if (cmd.step) begin
      rd_ptr_next = status.rd_last ? '0 : rd_ptr + AW'(1);
    end else begin
      rd_ptr_next = rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
    end
  end

  // Word store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[word_length[AW-1:0]] <= char_byte;
    end
    rd_data <= store[rd_ptr_next];
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        SEL_NL:   out_byte <= NL_BYTE;
        SEL_SP:   out_byte <= SP_BYTE;
        SEL_WORD: out_byte <= rd_data;
        default:  out_byte <= NL_BYTE;
      endcase
      last_of_run   <= cmd.last;
      width_error   <= error_sticky;
      word_overflow <= overflow_sticky;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("output register loaded while a beat is still waiting");

  a_word_bound: assert property (@(posedge clk) disable iff (rst)
    word_length <= WL_W'(MAX_WORD))
    else $error("word length beyond store depth");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    error_sticky |=> error_sticky)
    else $error("width error flag cleared");
`endif

endmodule

// ----- rtl/core/gww_ctrl.sv -----
// ----------------------------------------------------------------------------
// gww_ctrl
// Sequencer: takes an item, then walks separator, word bytes and newlines.
// ----------------------------------------------------------------------------
module gww_ctrl
  import gww_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gww_status_t status,
  output gww_cmd_t    cmd
);

  gww_state_t state;
  gww_state_t state_next;
  logic       sep_nl;
  logic       sep_nl_next;
  logic       tail_fin;
  logic       tail_fin_next;
  logic       tail_para;
  logic       tail_para_next;

  // Hold state and the plan latched at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sep_nl    <= 1'b0;
      tail_fin  <= 1'b0;
      tail_para <= 1'b0;
    end else begin
      state     <= state_next;
      sep_nl    <= sep_nl_next;
      tail_fin  <= tail_fin_next;
      tail_para <= tail_para_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    sep_nl_next    = sep_nl;
    tail_fin_next  = tail_fin;
    tail_para_next = tail_para;
    in_ready       = 1'b0;
    cmd            = '{accept: 1'b0, emit: 1'b0, sel: SEL_NL, last: 1'b0, step: 1'b0};
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.place) begin
            sep_nl_next    = status.need_nl;
            tail_fin_next  = status.flush;
            tail_para_next = status.para;
            if (status.pending) begin
              state_next = (status.need_nl || status.need_sp) ? ST_SEP : ST_WORD;
            end else if (status.flush) begin
              state_next = ST_FIN;
            end else if (status.para) begin
              state_next = ST_PARA1;
            end
          end
        end
      end
      ST_SEP: begin
        if (status.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.sel    = sep_nl ? SEL_NL : SEL_SP;
          state_next = ST_WORD;
        end
      end
      ST_WORD: begin
        if (status.emit_ok) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_WORD;
          cmd.step = 1'b1;
          cmd.last = status.rd_last && !tail_fin && !tail_para;
          if (status.rd_last) begin
            if (tail_fin) begin
              state_next = ST_FIN;
            end else if (tail_para) begin
              state_next = ST_PARA1;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      ST_PARA1: begin
        if (status.emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = ST_PARA2;
        end
      end
      ST_PARA2: begin
        if (status.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (status.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == ST_IDLE))
    else $error("final beat of a run did not return to idle");
`endif

endmodule

// ----- rtl/core/greedy_word_wrap_core.sv -----
// ----------------------------------------------------------------------------
// greedy_word_wrap_core
// Streaming greedy word wrapper with an APB line width register.
// ----------------------------------------------------------------------------
// A text byte that only extends the current word is taken while the core
// stays idle. A whitespace byte or an end of input item is taken and then
// followed by its output beats, one per cycle while the output side keeps
// up: an optional newline or space, the buffered word bytes (at most
// MAX_WORD) and up to two trailing newlines. This rate is set by the single
// read port of the word store, which yields one byte per cycle, and the one
// output register. No new item is taken until the last beat of the previous
// one is loaded; that beat may still wait downstream. The word store needs no
// clearing after reset. line_width sits at address 0.
module greedy_word_wrap_core
  import gww_pkg::*;
#(
  parameter int MAX_WORD = MAX_WORD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  gww_text_if.sink              text,
  gww_wrap_if.source            wrapped,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic        [7:0] line_width;
  gww_cmd_t          cmd;
  gww_status_t       status;

  // Configuration register: write in the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LINE_WIDTH)) begin
      line_width <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_LINE_WIDTH) ? {24'd0, line_width} : 32'd0;

  gww_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_ready (text.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gww_datapath #(
    .MAX_WORD (MAX_WORD)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .line_width    (line_width),
    .opcode        (text.opcode),
    .char_byte     (text.char_byte),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (wrapped.valid),
    .out_ready     (wrapped.ready),
    .out_byte      (wrapped.out_byte),
    .last_of_run   (wrapped.last_of_run),
    .width_error   (wrapped.width_error),
    .word_overflow (wrapped.word_overflow)
  );

endmodule

// ----- test/greedy_word_wrap_core_tb.sv -----
// ----------------------------------------------------------------------------
// greedy_word_wrap_core_tb
// Self-checking bench for the word wrap core. A directed table covers the
// edge cases, then several line width settings drive random text made mostly
// of words and separators. Every output beat is checked against an in-bench
// prediction of the wrapped stream, field by field.
// ----------------------------------------------------------------------------
module greedy_word_wrap_core_tb
  import gww_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int WORD_CAP      = MAX_WORD_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 58;
  localparam int LIMIT_NS      = 10_000_000;

  localparam logic [7:0] VT_BYTE = 8'd11;
  localparam logic [7:0] FF_BYTE = 8'd12;

  localparam logic [CFG_ADDR_W-1:0] ADDR_LINE_WIDTH = CFG_ADDR_W'(4 * REG_LINE_WIDTH);
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE      = CFG_ADDR_W'(4 * (REG_LINE_WIDTH + 1));

  typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_t;

  // One row of the directed table; typed_n < 0 leaves the check to prediction
  typedef struct {
    row_kind_t             kind;
    logic                  op;
    logic [7:0]            ch;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           data;
    int                    typed_n;
    logic [7:0]            typed0;
    logic [7:0]            typed1;
    logic                  typed_err;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       werr;
    logic       ovf;
  } wrap_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  gww_text_if text_ch ();
  gww_wrap_if wrap_ch ();

  greedy_word_wrap_core #(
    .MAX_WORD(WORD_CAP)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .wrapped (wrap_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted wrapper state
  logic [7:0] exp_width;
  logic [7:0] exp_word [WORD_CAP];
  int         exp_word_len;
  int         exp_line_len;
  bit         exp_nl_seen;
  bit         exp_para_done;
  bit         exp_width_err;
  bit         exp_overflow;
  logic [7:0] exp_run [$];

  wrap_beat_t wrapped_expect_q [$];
  int         items_sent = 0;
  int         beats_seen = 0;
  int         fail_count = 0;
  bit         sink_hold  = 1'b0;
  bit         no_gaps    = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR beat %0d %s: got 0x%0h want 0x%0h", beats_seen, what, got, want);
    fail_count++;
  endtask

  function automatic bit is_space_byte(input logic [7:0] c);
    return ((c >= TAB_BYTE) && (c <= CR_BYTE)) || (c == SP_BYTE);
  endfunction

  // Set the buffered word on the line, breaking first if it does not fit
  function automatic void place_pending();
    int need;
    int i;
    if (exp_word_len == 0) return;
    need = exp_line_len + exp_word_len + ((exp_line_len != 0) ? 1 : 0);
    if ((exp_line_len != 0) && (need > int'(exp_width))) begin
      exp_run.push_back(NL_BYTE);
      exp_line_len = 0;
    end
    if (exp_line_len != 0) begin
      exp_run.push_back(SP_BYTE);
      exp_line_len++;
    end
    for (i = 0; i < exp_word_len; i++) exp_run.push_back(exp_word[i]);
    exp_line_len += exp_word_len;
    if (exp_line_len > int'(exp_width)) exp_width_err = 1'b1;
    exp_line_len &= 255;
    exp_word_len = 0;
  endfunction

  // Advance the predicted state by one text beat; queue its output if asked
  function automatic void wrap_text_item(input logic op, input logic [7:0] ch, input bit keep);
    int k;
    exp_run.delete();
    if (op == OP_FLUSH) begin
      place_pending();
      exp_run.push_back(NL_BYTE);
      exp_word_len  = 0;
      exp_line_len  = 0;
      exp_nl_seen   = 1'b0;
      exp_para_done = 1'b0;
    end else if (is_space_byte(ch)) begin
      place_pending();
      if (ch == NL_BYTE) begin
        if (!exp_nl_seen) begin
          exp_nl_seen = 1'b1;
        end else if (!exp_para_done) begin
          exp_run.push_back(NL_BYTE);
          exp_run.push_back(NL_BYTE);
          exp_line_len  = 0;
          exp_nl_seen   = 1'b0;
          exp_para_done = 1'b1;
        end
      end
    end else begin
      if (exp_word_len < WORD_CAP) begin
        exp_word[exp_word_len] = ch;
        exp_word_len++;
      end else begin
        exp_overflow = 1'b1;
      end
      exp_nl_seen   = 1'b0;
      exp_para_done = 1'b0;
    end
    if (keep) begin
      for (k = 0; k < exp_run.size(); k++) begin
        wrapped_expect_q.push_back(wrap_beat_t'{exp_run[k], k == exp_run.size() - 1,
                                                exp_width_err, exp_overflow});
      end
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (is_space_byte(c));
    return c;
  endfunction

  function automatic logic [7:0] other_space();
    case ($urandom_range(0, 3))
      0: return TAB_BYTE;
      1: return VT_BYTE;
      2: return FF_BYTE;
      default: return CR_BYTE;
    endcase
  endfunction

  function automatic dir_row_t text_row(input logic op, input logic [7:0] ch);
    dir_row_t r;
    r = '{ROW_TEXT, op, ch, '0, '0, -1, 8'h00, 8'h00, 1'b0};
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic op, input logic [7:0] ch, input int n,
                                         input logic [7:0] b0, input logic [7:0] b1,
                                         input logic err);
    dir_row_t r;
    r = '{ROW_TEXT, op, ch, '0, '0, n, b0, b1, err};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                       input logic [31:0] data);
    dir_row_t r;
    r = '{ROW_CFG, OP_TEXT, 8'h00, addr, data, -1, 8'h00, 8'h00, 1'b0};
    return r;
  endfunction

  // Offer one text beat and hold it until the core takes it
  task automatic send_item(input logic op, input logic [7:0] ch, input bit keep);
    text_ch.valid     <= 1'b1;
    text_ch.opcode    <= op;
    text_ch.char_byte <= ch;
    do @(posedge clk); while (!text_ch.ready);
    wrap_text_item(op, ch, keep);
    items_sent++;
  endtask

  task automatic text_pause();
    int gap;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer(input logic op, input logic [7:0] ch);
    send_item(op, ch, 1'b1);
    text_pause();
  endtask

  // Stop offering and wait out every outstanding beat
  task automatic drain_text();
    text_ch.valid <= 1'b0;
    while (wrapped_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_LINE_WIDTH) exp_width = data[7:0];
    @(posedge clk);
  endtask

  // One random stretch of text: mostly a word and a separator
  task automatic send_unit();
    int r;
    int len;
    int i;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 9);
      else if (r < 95) len = $urandom_range(10, 28);
      else len = $urandom_range(29, 40);
      for (i = 0; i < len; i++) offer(OP_TEXT, word_byte());
      r = $urandom_range(0, 99);
      if (r < 60) begin
        offer(OP_TEXT, SP_BYTE);
      end else if (r < 75) begin
        offer(OP_TEXT, NL_BYTE);
      end else if (r < 85) begin
        offer(OP_TEXT, NL_BYTE);
        offer(OP_TEXT, NL_BYTE);
        if ($urandom_range(0, 1) == 1) offer(OP_TEXT, NL_BYTE);
      end else if (r < 95) begin
        offer(OP_TEXT, other_space());
      end
      // otherwise run straight on into the next word
    end else if (r < 82) begin
      len = $urandom_range(1, 4);
      for (i = 0; i < len; i++) begin
        offer(OP_TEXT, ($urandom_range(0, 1) == 1) ? NL_BYTE : other_space());
      end
    end else if (r < 90) begin
      offer(OP_FLUSH, 8'($urandom));
    end else begin
      offer(OP_TEXT, 8'($urandom));
    end
  endtask

  // Output side: random back-pressure, plus one long hold on request
  initial begin : wrap_sink
    int n;
    wrap_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (sink_hold) begin
        wrap_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
      end else if (no_gaps) begin
        wrap_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          wrap_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        wrap_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Check each accepted output beat against the oldest expectation
  always @(posedge clk) begin : wrap_check
    wrap_beat_t want;
    if (!rst && wrap_ch.valid && wrap_ch.ready) begin
      if (wrapped_expect_q.size() == 0) begin
        report_mismatch("unexpected beat", wrap_ch.out_byte, 0);
      end else begin
        want = wrapped_expect_q.pop_front();
        if (wrap_ch.out_byte !== want.out_byte)
          report_mismatch("out_byte", wrap_ch.out_byte, want.out_byte);
        if (wrap_ch.last_of_run !== want.last)
          report_mismatch("last_of_run", wrap_ch.last_of_run, want.last);
        if (wrap_ch.width_error !== want.werr)
          report_mismatch("width_error", wrap_ch.width_error, want.werr);
        if (wrap_ch.word_overflow !== want.ovf)
          report_mismatch("word_overflow", wrap_ch.word_overflow, want.ovf);
      end
      beats_seen++;
    end
  end

  initial begin : stimulus
    dir_row_t   rows [$];
    dir_row_t   row;
    int         k;
    int         p;
    int         phase_start;
    bit         held;
    bit         paused;
    logic [7:0] width_sel;

    text_ch.valid     <= 1'b0;
    text_ch.opcode    <= OP_TEXT;
    text_ch.char_byte <= 8'h00;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;

    exp_width     = LINE_WIDTH_RST;
    exp_word_len  = 0;
    exp_line_len  = 0;
    exp_nl_seen   = 1'b0;
    exp_para_done = 1'b0;
    exp_width_err = 1'b0;
    exp_overflow  = 1'b0;
    held          = 1'b0;
    paused        = 1'b0;

    // Flush on an empty core, then the blank line rules
    rows.push_back(typed_row(OP_FLUSH, 8'hFF, 1, NL_BYTE, 8'h00, 1'b0));
    rows.push_back(typed_row(OP_TEXT, NL_BYTE, 0, 8'h00, 8'h00, 1'b0));
    rows.push_back(typed_row(OP_TEXT, NL_BYTE, 2, NL_BYTE, NL_BYTE, 1'b0));
    rows.push_back(typed_row(OP_TEXT, NL_BYTE, 0, 8'h00, 8'h00, 1'b0));
    // First word of a line takes no separator; byte extremes as word text
    rows.push_back(text_row(OP_TEXT, 8'h61));
    rows.push_back(typed_row(OP_TEXT, TAB_BYTE, 1, 8'h61, 8'h00, 1'b0));
    rows.push_back(text_row(OP_TEXT, 8'hFF));
    rows.push_back(text_row(OP_TEXT, 8'h00));
    rows.push_back(text_row(OP_TEXT, CR_BYTE));
    rows.push_back(text_row(OP_TEXT, VT_BYTE));
    rows.push_back(text_row(OP_TEXT, FF_BYTE));
    rows.push_back(text_row(OP_TEXT, SP_BYTE));
    // Narrowest width: break before the word, then it still overruns
    rows.push_back(cfg_row(ADDR_LINE_WIDTH, 32'd1));
    rows.push_back(text_row(OP_TEXT, 8'h78));
    rows.push_back(text_row(OP_TEXT, 8'h79));
    rows.push_back(text_row(OP_TEXT, SP_BYTE));
    // Unmapped register must leave the width alone
    rows.push_back(cfg_row(ADDR_SPARE, 32'hFFFF_FFFF));
    rows.push_back(text_row(OP_TEXT, 8'h7A));
    rows.push_back(text_row(OP_FLUSH, 8'h00));
    // Zero width: every word overruns, even alone on a line
    rows.push_back(cfg_row(ADDR_LINE_WIDTH, 32'd0));
    rows.push_back(text_row(OP_TEXT, 8'h71));
    rows.push_back(text_row(OP_TEXT, 8'h72));
    rows.push_back(text_row(OP_TEXT, NL_BYTE));
    rows.push_back(text_row(OP_TEXT, 8'h77));
    rows.push_back(text_row(OP_FLUSH, 8'hA5));
    rows.push_back(typed_row(OP_FLUSH, 8'h00, 1, NL_BYTE, 8'h00, 1'b1));
    // Widest setting, upper data bits ignored
    rows.push_back(cfg_row(ADDR_LINE_WIDTH, 32'hFFFF_FFFF));
    rows.push_back(text_row(OP_TEXT, 8'h80));
    rows.push_back(text_row(OP_FLUSH, 8'h5A));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_CFG) begin
        drain_text();
        apb_write(row.addr, row.data);
      end else begin
        send_item(row.op, row.ch, row.typed_n < 0);
        for (k = 0; k < row.typed_n; k++) begin
          wrapped_expect_q.push_back(wrap_beat_t'{(k == 0) ? row.typed0 : row.typed1,
                                                  k == row.typed_n - 1, row.typed_err, 1'b0});
        end
        text_pause();
      end
    end

    // Random text under a sweep of line widths
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: width_sel = 8'd255;
        1: width_sel = 8'd1;
        2: width_sel = 8'($urandom_range(4, 16));
        3: width_sel = 8'($urandom_range(17, 100));
        4: width_sel = 8'($urandom_range(1, 255));
        default: width_sel = LINE_WIDTH_RST;
      endcase
      drain_text();
      apb_write(ADDR_LINE_WIDTH, {24'($urandom), width_sel});
      no_gaps     = (p == 3);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // Long output stall while input keeps coming
        if (p == 1 && !held && items_sent - phase_start > 10) begin
          sink_hold = 1'b1;
          held      = 1'b1;
        end
        // Let the output fully empty mid-stream
        if (p == 2 && !paused && items_sent - phase_start > 20) begin
          drain_text();
          paused = 1'b1;
        end
        send_unit();
      end
    end

    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (wrapped_expect_q.size() != 0)
      report_mismatch("beats never seen", 0, wrapped_expect_q.size());
    if (fail_count == 0) begin
      $display("greedy_word_wrap_core regression: pass");
    end else begin
      $display("greedy_word_wrap_core regression: fail");
    end
    $finish;
  end

  initial begin : run_limit
    #(LIMIT_NS);
    $display("greedy_word_wrap_core regression: fail");
    $finish;
  end

endmodule

// ----- greedy_word_wrap_core.f -----
rtl/core/gww_pkg.sv
rtl/core/gww_if.sv
rtl/core/gww_datapath.sv
rtl/core/gww_ctrl.sv
rtl/core/greedy_word_wrap_core.sv
test/greedy_word_wrap_core_tb.sv
